FILE: design/sal_pkg.sv
// Shared types and constants for the shelf atlas allocator.
// No dependencies; imported by sal_ram users and the top level.
package sal_pkg;

	localparam int OUT_W     = 14;  // width of every coordinate and size result field
	localparam int RECT_W    = 11;  // rectangle width and height fields
	localparam int ROW_HGT_W = 12;  // stored row height: h + h/10 reaches 2251
	localparam int FILL_W    = 16;  // 10*h against min_fill*row_height
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 8;

	// floor(h/10) as (h * RECIP) >> RECIP_SHIFT, exact for h below 2048
	localparam int RECIP       = 6554;
	localparam int RECIP_SHIFT = 16;
	localparam int PROD_W      = 25;

	localparam logic [7:0] FIRST_ROW_TOP_RST = 8'd3;
	localparam logic [3:0] MIN_FILL_RST      = 4'd7;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROW_TOP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_FILL      = 1'd1;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_TABLE_FULL = 2'd1;
	localparam logic [1:0] STATUS_ATLAS_FULL = 2'd2;

	localparam logic MODE_CLEAR = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SIZE,
		ST_GROW,
		ST_RESP
	} state_t;

	function automatic logic [OUT_W-1:0] fit_out(input logic [31:0] v);
		return v[OUT_W-1:0];
	endfunction

endpackage

FILE: design/sal_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/shelf_atlas_allocator.sv
// Shelf allocator for a square texture atlas: first-fit row search, new rows, side doubling.
// A clear goes straight to the response; an allocation scans the rows for a first fit, else
// opens a new row (or reports a full table), doubling both sides until the row fits or
// MAX_SIDE would be passed. One beat is in work at a time. Reset zeroes the row count and
// restores next top, sides and config registers; the row memory needs no clearing pass.
// Depends on sal_pkg and sal_ram.
module shelf_atlas_allocator #(
	parameter int MAX_ROWS     = 256,
	parameter int MAX_SIDE     = 8192,
	parameter int INITIAL_SIDE = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_we,
	input  logic [sal_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sal_pkg::CFG_DAT_W-1:0]  cfg_data,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           mode,
	input  logic [sal_pkg::RECT_W-1:0]     rect_width,
	input  logic [sal_pkg::RECT_W-1:0]     rect_height,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [sal_pkg::OUT_W-1:0]      pos_x,
	output logic [sal_pkg::OUT_W-1:0]      pos_y,
	output logic [sal_pkg::OUT_W-1:0]      atlas_width,
	output logic [sal_pkg::OUT_W-1:0]      atlas_height,
	output logic                           grew,
	output logic                           new_row,
	output logic [1:0]                     status
);

	import sal_pkg::*;

	// Side registers must hold both the initial side and every doubled side.
	localparam int SMAX   = (MAX_SIDE > INITIAL_SIDE) ? MAX_SIDE : INITIAL_SIDE;
	localparam int SIDE_W = $clog2(SMAX + 1);
	localparam int NT_W   = (SIDE_W > 8) ? SIDE_W : 8;
	localparam int SUM_W  = ((NT_W > ROW_HGT_W) ? NT_W : ROW_HGT_W) + 1;
	localparam int UW     = ((SIDE_W > RECT_W) ? SIDE_W : RECT_W) + 1;
	localparam int DBL_W  = SIDE_W + 1;
	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNT_W  = $clog2(MAX_ROWS + 1);
	// Row word: {top, height, used}
	localparam int WORD_W = SIDE_W + ROW_HGT_W + SIDE_W;

	state_t state_q, state_d;

	logic [7:0]          first_row_top_q;
	logic [3:0]          min_fill_q;

	logic [CNT_W-1:0]    row_count_q;
	logic [NT_W-1:0]     next_top_q;
	logic [SIDE_W-1:0]   side_w_q, side_h_q;

	// Per-beat working registers
	logic [RECT_W-1:0]   w_q, h_q;
	logic [CNT_W-1:0]    idx_q;       // next entry to read
	logic [ROW_W-1:0]    eidx_q;      // entry whose read data is arriving
	logic                pend_q;
	logic [ROW_HGT_W-1:0] rh_q;
	logic [SIDE_W-1:0]   try_w_q, try_h_q;
	logic                grew_q;

	// Finished result, held until the output register frees up
	logic [OUT_W-1:0]    res_x_q, res_y_q;
	logic                res_grew_q, res_new_q;
	logic [1:0]          res_status_q;

	logic                out_valid_q;
	logic [OUT_W-1:0]    out_x_q, out_y_q, out_w_q, out_h_q;
	logic                out_grew_q, out_new_q;
	logic [1:0]          out_status_q;

	// Row memory ports
	logic                ram_we, ram_re;
	logic [ROW_W-1:0]    ram_waddr;
	logic [WORD_W-1:0]   ram_wdata, ram_rdata;

	sal_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_ROWS)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q[ROW_W-1:0]),
		.rdata (ram_rdata)
	);

	// Fields of the row word coming back from memory
	logic [SIDE_W-1:0]    rd_used, rd_top;
	logic [ROW_HGT_W-1:0] rd_h;
	assign rd_used = ram_rdata[SIDE_W-1:0];
	assign rd_h    = ram_rdata[SIDE_W +: ROW_HGT_W];
	assign rd_top  = ram_rdata[SIDE_W+ROW_HGT_W +: SIDE_W];

	// First-fit test on the entry just read: fill ratio, height, remaining width
	logic [FILL_W-1:0] fill_lhs, fill_rhs;
	logic [UW-1:0]     used_sum;
	logic              hit, more;
	assign fill_lhs = FILL_W'({h_q, 3'b000}) + FILL_W'({h_q, 1'b0});
	assign fill_rhs = FILL_W'(min_fill_q) * FILL_W'(rd_h);
	assign used_sum = UW'(rd_used) + UW'(w_q);
	assign hit  = pend_q && (fill_lhs >= fill_rhs) && (ROW_HGT_W'(h_q) <= rd_h)
	              && (used_sum <= UW'(side_w_q));
	assign more = (idx_q < row_count_q);

	// New row height: h + floor(h/10) by reciprocal multiply
	logic [PROD_W-1:0]    rh_prod;
	logic [ROW_HGT_W-1:0] rh_new;
	assign rh_prod = PROD_W'(h_q) * PROD_W'(RECIP);
	assign rh_new  = ROW_HGT_W'(h_q) + ROW_HGT_W'(rh_prod >> RECIP_SHIFT);

	logic table_full;
	assign table_full = (row_count_q >= CNT_W'(MAX_ROWS));

	// Growth test on the trial sides: does the new row still miss, and would doubling overflow
	logic [SUM_W-1:0] row_bottom;
	logic             need_grow, over_max;
	assign row_bottom = SUM_W'(next_top_q) + SUM_W'(rh_q);
	assign need_grow  = (row_bottom >= SUM_W'(try_h_q)) || (UW'(w_q) >= UW'(try_w_q));
	assign over_max   = (DBL_W'({try_w_q, 1'b0}) > DBL_W'(MAX_SIDE))
	                    || (DBL_W'({try_h_q, 1'b0}) > DBL_W'(MAX_SIDE));

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (mode == MODE_CLEAR) ? ST_RESP : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = ST_RESP;
				end else if (!more && !pend_q) begin
					state_d = ST_SIZE;
				end
			end
			ST_SIZE: begin
				state_d = table_full ? ST_RESP : ST_GROW;
			end
			ST_GROW: begin
				if (!need_grow || over_max) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake and memory control
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		ram_re    = (state_q == ST_SCAN) && more && !hit;
		ram_we    = 1'b0;
		ram_waddr = eidx_q;
		ram_wdata = {rd_top, rd_h, SIDE_W'(used_sum)};
		case (state_q)
			ST_SCAN: begin
				ram_we = hit;
			end
			ST_GROW: begin
				ram_we    = !need_grow;
				ram_waddr = row_count_q[ROW_W-1:0];
				ram_wdata = {SIDE_W'(next_top_q), rh_q, SIDE_W'(w_q)};
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration: written whenever the write enable is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_row_top_q <= FIRST_ROW_TOP_RST;
			min_fill_q      <= MIN_FILL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_ROW_TOP: first_row_top_q <= cfg_data;
				CFG_MIN_FILL:      min_fill_q      <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Allocator state: row count, next free top, atlas sides, scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
			next_top_q  <= NT_W'(FIRST_ROW_TOP_RST);
			side_w_q    <= SIDE_W'(INITIAL_SIDE);
			side_h_q    <= SIDE_W'(INITIAL_SIDE);
			idx_q       <= '0;
			pend_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q  <= '0;
					pend_q <= 1'b0;
					if (in_valid && mode == MODE_CLEAR) begin
						// Drop all rows; the atlas keeps its size
						row_count_q <= '0;
						next_top_q  <= NT_W'(first_row_top_q);
					end
				end
				ST_SCAN: begin
					// Advance one entry per cycle; the pending flag tracks read latency
					pend_q <= ram_re;
					if (ram_re) begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_GROW: begin
					if (!need_grow) begin
						side_w_q    <= try_w_q;
						side_h_q    <= try_h_q;
						row_count_q <= row_count_q + CNT_W'(1);
						next_top_q  <= NT_W'(row_bottom);
					end
				end
				default: ;
			endcase
		end
	end

	// Per-beat payload registers and the held result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				w_q          <= rect_width;
				h_q          <= rect_height;
				res_x_q      <= '0;
				res_y_q      <= '0;
				res_grew_q   <= 1'b0;
				res_new_q    <= 1'b0;
				res_status_q <= STATUS_OK;
			end
			ST_SCAN: begin
				if (ram_re) begin
					eidx_q <= idx_q[ROW_W-1:0];
				end
				if (hit) begin
					res_x_q <= fit_out(32'(rd_used));
					res_y_q <= fit_out(32'(rd_top));
				end
			end
			ST_SIZE: begin
				rh_q    <= rh_new;
				try_w_q <= side_w_q;
				try_h_q <= side_h_q;
				grew_q  <= 1'b0;
				if (table_full) begin
					res_status_q <= STATUS_TABLE_FULL;
				end
			end
			ST_GROW: begin
				if (!need_grow) begin
					res_y_q    <= fit_out(32'(next_top_q));
					res_grew_q <= grew_q;
					res_new_q  <= 1'b1;
				end else if (over_max) begin
					res_status_q <= STATUS_ATLAS_FULL;
				end else begin
					// Double both sides together and test again
					try_w_q <= {try_w_q[SIDE_W-2:0], 1'b0};
					try_h_q <= {try_h_q[SIDE_W-2:0], 1'b0};
					grew_q  <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Output register: loads the held result once the previous beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			out_x_q      <= res_x_q;
			out_y_q      <= res_y_q;
			out_w_q      <= fit_out(32'(side_w_q));
			out_h_q      <= fit_out(32'(side_h_q));
			out_grew_q   <= res_grew_q;
			out_new_q    <= res_new_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign pos_x        = out_x_q;
	assign pos_y        = out_y_q;
	assign atlas_width  = out_w_q;
	assign atlas_height = out_h_q;
	assign grew         = out_grew_q;
	assign new_row      = out_new_q;
	assign status       = out_status_q;

endmodule

FILE: tb/tb_shelf_atlas_allocator.sv
// Self-checking testbench for the shelf atlas allocator: first-fit rows, growth, clears.
// Predicts every placement in-bench and checks each result beat in order.
// Depends on sal_pkg and the shelf_atlas_allocator RTL only.
module tb_shelf_atlas_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import sal_pkg::*;

	localparam int MAX_ROWS     = 256;
	localparam int MAX_SIDE     = 8192;
	localparam int INITIAL_SIDE = 128;

	localparam logic MODE_ALLOC = ~MODE_CLEAR;

	localparam int HALF_PERIOD   = 6;
	localparam int DRAIN_LIMIT   = 20000;   // cycles to wait for pending placements
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = MAX_ROWS + 20;
	localparam int HOLD_CYCLES   = 300;     // long receiver stall for the pressure test
	localparam int RANDOM_ITEMS  = 525;
	localparam int RANDOM_PHASES = 5;
	localparam int REPORT_LIMIT  = 10;

	// One placement result, in port order
	typedef struct packed {
		logic [OUT_W-1:0] pos_x;
		logic [OUT_W-1:0] pos_y;
		logic [OUT_W-1:0] atlas_width;
		logic [OUT_W-1:0] atlas_height;
		logic             grew;
		logic             new_row;
		logic [1:0]       status;
	} placement_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 mode;
	logic [RECT_W-1:0]    rect_width;
	logic [RECT_W-1:0]    rect_height;
	logic                 out_valid;
	logic                 out_ready;
	logic [OUT_W-1:0]     pos_x;
	logic [OUT_W-1:0]     pos_y;
	logic [OUT_W-1:0]     atlas_width;
	logic [OUT_W-1:0]     atlas_height;
	logic                 grew;
	logic                 new_row;
	logic [1:0]           status;

	shelf_atlas_allocator #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_SIDE    (MAX_SIDE),
		.INITIAL_SIDE(INITIAL_SIDE)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.atlas_width (atlas_width),
		.atlas_height(atlas_height),
		.grew        (grew),
		.new_row     (new_row),
		.status      (status)
	);

	// Shelf model state: row table, stacking point, atlas sides, registers
	int shelf_top  [MAX_ROWS];
	int shelf_hgt  [MAX_ROWS];
	int shelf_used [MAX_ROWS];
	int shelves_open   = 0;
	int next_shelf_top = FIRST_ROW_TOP_RST;
	int side_w         = INITIAL_SIDE;
	int side_h         = INITIAL_SIDE;
	int reg_first_top  = FIRST_ROW_TOP_RST;
	int reg_min_fill   = MIN_FILL_RST;

	placement_t placement_q[$];   // placements still owed by the block, oldest first

	int fail_count   = 0;
	int burst_left   = 0;   // beats left in the current sender burst
	int hold_request = 0;   // long receiver stall asked for by a test, in cycles

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	// Apply one beat to the shelf model and return the placement it owes.
	function automatic placement_t predict_placement(input logic m,
			input logic [RECT_W-1:0] w_in, input logic [RECT_W-1:0] h_in);
		placement_t r;
		int w, h, rh, sw, sh, i;
		bit grown;
		w = w_in;
		h = h_in;
		r = '0;
		r.atlas_width  = OUT_W'(side_w);
		r.atlas_height = OUT_W'(side_h);
		// Clear: drop every row, restart stacking, keep the atlas size
		if (m == MODE_CLEAR) begin
			shelves_open   = 0;
			next_shelf_top = reg_first_top;
			return r;
		end
		// First fit: row tall enough, not too tall for the fill ratio, wide enough
		for (i = 0; i < shelves_open; i++) begin
			if (10 * h < reg_min_fill * shelf_hgt[i])
				continue;
			if (h > shelf_hgt[i])
				continue;
			if (shelf_used[i] + w > side_w)
				continue;
			r.pos_x = OUT_W'(shelf_used[i]);
			r.pos_y = OUT_W'(shelf_top[i]);
			shelf_used[i] += w;
			return r;
		end
		if (shelves_open >= MAX_ROWS) begin
			r.status = STATUS_TABLE_FULL;
			return r;
		end
		// Open a new row 10% taller; double both sides until it fits
		rh    = h + h / 10;
		sw    = side_w;
		sh    = side_h;
		grown = 1'b0;
		while (next_shelf_top + rh >= sh || w >= sw) begin
			if (sw * 2 > MAX_SIDE || sh * 2 > MAX_SIDE) begin
				r.status = STATUS_ATLAS_FULL;
				return r;
			end
			sw *= 2;
			sh *= 2;
			grown = 1'b1;
		end
		side_w = sw;
		side_h = sh;
		shelf_top[shelves_open]  = next_shelf_top;
		shelf_hgt[shelves_open]  = rh;
		shelf_used[shelves_open] = w;
		shelves_open++;
		r.pos_y        = OUT_W'(next_shelf_top);
		r.atlas_width  = OUT_W'(sw);
		r.atlas_height = OUT_W'(sh);
		r.grew         = grown;
		r.new_row      = 1'b1;
		next_shelf_top += rh;
		return r;
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("ERROR: %s", msg);
	endfunction

	// Mostly small rectangles so rows get reused; a few huge ones force growth
	function automatic void random_rect(output logic [RECT_W-1:0] w,
			output logic [RECT_W-1:0] h);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			w = RECT_W'($urandom_range(1, 32));
			h = RECT_W'($urandom_range(1, 24));
		end else if (pick < 85) begin
			w = RECT_W'($urandom_range(1, 256));
			h = RECT_W'($urandom_range(1, 256));
		end else if (pick < 95) begin
			w = RECT_W'($urandom_range(1, 1024));
			h = RECT_W'($urandom_range(1, 1024));
		end else begin
			w = RECT_W'($urandom_range(0, 2047));
			h = RECT_W'($urandom_range(0, 2047));
		end
	endfunction

	// Offer one beat; sometimes idle between bursts, hold valid and payload until accepted.
	task automatic send_item(input logic m, input logic [RECT_W-1:0] w,
			input logic [RECT_W-1:0] h);
		int gap;
		if (burst_left <= 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid    <= 1'b1;
		mode        <= m;
		rect_width  <= w;
		rect_height <= h;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		placement_q.push_back(predict_placement(m, w, h));
		burst_left--;
	endtask

	// Drop valid and wait until every owed placement has come back.
	task automatic wait_results_drained();
		int waited;
		waited     = 0;
		burst_left = 0;
		in_valid <= 1'b0;
		while (placement_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (placement_q.size() != 0) begin
			note_failure($sformatf("%0d placements never arrived", placement_q.size()));
			placement_q.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers on back-to-back cycles; call only while idle.
	task automatic write_registers(input logic [7:0] first_top, input logic [3:0] min_fill);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_FIRST_ROW_TOP;
		cfg_data  <= first_top;
		@(posedge clk);
		cfg_index <= CFG_MIN_FILL;
		cfg_data  <= CFG_DAT_W'(min_fill);
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_first_top = first_top;
		reg_min_fill  = min_fill;
	endtask

	// Reset values: reuse, zero sizes, growth from the smallest to the largest rect
	task automatic test_reset_values();
		send_item(MODE_ALLOC, 11'd10, 11'd10);
		send_item(MODE_ALLOC, 11'd20, 11'd9);
		send_item(MODE_ALLOC, 11'd0, 11'd11);
		send_item(MODE_ALLOC, 11'd5, 11'd0);
		send_item(MODE_ALLOC, 11'd5, 11'd0);
		send_item(MODE_ALLOC, 11'd127, 11'd7);
		send_item(MODE_ALLOC, 11'd128, 11'd5);
		send_item(MODE_ALLOC, 11'd1024, 11'd1024);
		send_item(MODE_ALLOC, 11'd2047, 11'd2047);
		send_item(MODE_ALLOC, 11'd1, 11'd1);
		send_item(MODE_CLEAR, 11'd0, 11'd0);
		send_item(MODE_ALLOC, 11'd1, 11'd1);
	endtask

	// A new first row top must wait for the next clear; fill ratio extremes
	task automatic test_register_update();
		wait_results_drained();
		write_registers(8'd0, 4'd0);
		send_item(MODE_ALLOC, 11'd3, 11'd3);
		send_item(MODE_CLEAR, 11'h7FF, 11'h7FF);
		send_item(MODE_ALLOC, 11'd4, 11'd0);
		send_item(MODE_ALLOC, 11'd4, 11'd0);
		send_item(MODE_ALLOC, 11'd9, 11'd1);
		send_item(MODE_ALLOC, 11'd9, 11'd30);
		send_item(MODE_ALLOC, 11'd9, 11'd1);
		wait_results_drained();
		write_registers(8'd255, 4'd10);
		send_item(MODE_ALLOC, 11'd9, 11'd30);
		send_item(MODE_CLEAR, 11'd0, 11'd0);
		send_item(MODE_ALLOC, 11'd1, 11'd1);
	endtask

	// Full fill ratio: a 10-texel rect never reuses its 11-texel row, so every beat
	// opens a row until the table is exhausted. An exact-height rect still fits.
	task automatic test_table_full();
		int k;
		wait_results_drained();
		write_registers(8'd255, 4'd10);
		send_item(MODE_CLEAR, 11'd0, 11'd0);
		for (k = 0; k < MAX_ROWS; k++)
			send_item(MODE_ALLOC, RECT_W'($urandom_range(1, 64)), 11'd10);
		send_item(MODE_ALLOC, 11'd5, 11'd10);
		send_item(MODE_ALLOC, 11'd2047, 11'd10);
		send_item(MODE_ALLOC, 11'd7, 11'd11);
		send_item(MODE_CLEAR, 11'd0, 11'd0);
	endtask

	// Stack tall rows until the atlas would need to pass its largest side
	task automatic test_atlas_full();
		int k;
		wait_results_drained();
		write_registers(8'($urandom_range(0, 255)), 4'd10);
		send_item(MODE_CLEAR, 11'd0, 11'd0);
		for (k = 0; k < 10; k++)
			send_item(MODE_ALLOC, RECT_W'($urandom_range(1, 2047)), 11'd1024);
		send_item(MODE_ALLOC, 11'd2047, 11'd2047);
		send_item(MODE_CLEAR, 11'd0, 11'd0);
	endtask

	// Stall the receiver for a long stretch while beats keep coming
	task automatic test_backpressure();
		int k;
		logic [RECT_W-1:0] w, h;
		wait_results_drained();
		hold_request = HOLD_CYCLES;
		burst_left   = 40;
		for (k = 0; k < 30; k++) begin
			random_rect(w, h);
			send_item(MODE_ALLOC, w, h);
		end
	endtask

	// Random mix over several register settings, extremes first
	task automatic test_random_mix();
		int phase, k;
		logic [RECT_W-1:0] w, h;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_results_drained();
			case (phase)
				0: begin
					write_registers(8'd0, 4'd0);
				end
				1: begin
					write_registers(8'd255, 4'd10);
				end
				2: begin
					write_registers(FIRST_ROW_TOP_RST, MIN_FILL_RST);
				end
				default: begin
					write_registers(8'($urandom_range(0, 255)), 4'($urandom_range(0, 10)));
				end
			endcase
			for (k = 0; k < RANDOM_ITEMS / RANDOM_PHASES; k++) begin
				random_rect(w, h);
				// roughly one clear in 25 beats keeps the row table short
				if ($urandom_range(0, 24) == 0)
					send_item(MODE_CLEAR, w, h);
				else
					send_item(MODE_ALLOC, w, h);
			end
		end
	endtask

	// Receiver: change stall style after each random span; serve a long hold on request
	initial begin : rx_stall_pattern
		int style, span, k, held;
		out_ready <= 1'b1;
		forever begin
			style = $urandom_range(0, 3);
			span  = $urandom_range(8, 64);
			for (k = 0; k < span; k++) begin
				@(posedge clk);
				if (hold_request > 0) begin
					held         = hold_request;
					hold_request = 0;
					out_ready <= 1'b0;
					repeat (held) @(posedge clk);
				end
				case (style)
					0: begin
						out_ready <= 1'b1;
					end
					1: begin
						out_ready <= 1'($urandom_range(0, 1));
					end
					2: begin
						out_ready <= ($urandom_range(0, 7) != 0);
					end
					default: begin
						out_ready <= ($urandom_range(0, 3) == 0);
					end
				endcase
			end
		end
	end

	// Check each result beat against the oldest owed placement
	task automatic check_placement();
		placement_t want, got;
		got = {pos_x, pos_y, atlas_width, atlas_height, grew, new_row, status};
		if (placement_q.size() == 0) begin
			note_failure($sformatf("result beat at %0t with nothing owed", $time));
			return;
		end
		want = placement_q.pop_front();
		if (got !== want)
			note_failure($sformatf({"placement at %0t: expected x=%0d y=%0d ",
				"atlas=%0dx%0d grew=%0d new_row=%0d status=%0d, got x=%0d y=%0d ",
				"atlas=%0dx%0d grew=%0d new_row=%0d status=%0d"}, $time,
				want.pos_x, want.pos_y, want.atlas_width, want.atlas_height,
				want.grew, want.new_row, want.status,
				got.pos_x, got.pos_y, got.atlas_width, got.atlas_height,
				got.grew, got.new_row, got.status));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_placement();
	end

	// Hard stop well beyond the slowest legal run
	initial begin : watchdog
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : run_tests
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= CFG_FIRST_ROW_TOP;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		mode        <= MODE_ALLOC;
		rect_width  <= '0;
		rect_height <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_register_update();
		test_table_full();
		test_atlas_full();
		test_backpressure();
		test_random_mix();

		// Drain, then give a stray late beat time to show up
		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
